FILE: rtl/epps_pkg.sv
// Shared types, register codes and the microcode program of the encoder speed loop.
// Used by the datapath, sequencer, top level and bench; depends on nothing.
`default_nettype none

package epps_pkg;

  localparam int unsigned STEP_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [STEP_W-1:0] step_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE   = 3'd5;

  localparam logic [23:0] SPEED_MAX      = 24'hFF_FFFF;
  localparam logic [71:0] ITERM_LIM      = 72'h00_4000_0000_0000_0000;
  localparam logic [5:0]  SPEED_DIV_LAST = 6'd31;
  localparam logic [5:0]  D_DIV_LAST     = 6'd57;

  // Microcode addresses.
  localparam step_t STEP_WAIT      = 4'd0;
  localparam step_t STEP_PREP      = 4'd1;
  localparam step_t STEP_SPEED_DIV = 4'd2;
  localparam step_t STEP_SPEED     = 4'd3;
  localparam step_t STEP_ERR       = 4'd4;
  localparam step_t STEP_MUL_P     = 4'd5;
  localparam step_t STEP_ACC_P     = 4'd6;
  localparam step_t STEP_LOAD_D    = 4'd7;
  localparam step_t STEP_MUL_IH    = 4'd8;
  localparam step_t STEP_ADD_IH    = 4'd9;
  localparam step_t STEP_D_DIV     = 4'd10;
  localparam step_t STEP_ACC_D     = 4'd11;
  localparam step_t STEP_ACC_I     = 4'd12;
  localparam step_t STEP_DRIVE     = 4'd13;
  localparam step_t STEP_HOLD      = 4'd14;
  localparam step_t STEP_FINISH    = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PREP,
    OP_DIV,
    OP_SPEED,
    OP_ERR,
    OP_MUL_P,
    OP_ACC_P,
    OP_LOAD_D,
    OP_MUL_IH,
    OP_ADD_IH,
    OP_ACC_D,
    OP_ACC_I,
    OP_DRIVE,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_START,
    JMP_SKIP,
    JMP_CNT_NZ,
    JMP_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic skip;
    logic cnt_nz;
    logic out_busy;
  } seq_status_t;

  typedef struct packed {
    logic skip;
    logic cnt_nz;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] tick_time;
  } in_t;

  typedef struct packed {
    logic [31:0]        pulse_total;
    logic               updated;
    logic [23:0]        speed_measured;
    logic signed [31:0] drive_out;
    logic               run_state;
  } out_t;

  typedef struct packed {
    logic [31:0]        pulse_scale;
    logic [23:0]        target_speed;
    logic signed [31:0] prop_gain;
    logic signed [31:0] int_gain;
    logic signed [31:0] deriv_gain;
    logic               run_enable;
  } cfg_t;

  // The control program. A step either falls through or jumps when its condition holds.
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw.op     = OP_NONE;
    cw.cond   = JMP_NEVER;
    cw.target = STEP_WAIT;
    case (step)
      STEP_WAIT: begin
        cw.cond   = JMP_NO_START;
        cw.target = STEP_WAIT;
      end
      STEP_PREP: begin
        cw.op     = OP_PREP;
        cw.cond   = JMP_SKIP;
        cw.target = STEP_HOLD;
      end
      STEP_SPEED_DIV: begin
        cw.op     = OP_DIV;
        cw.cond   = JMP_CNT_NZ;
        cw.target = STEP_SPEED_DIV;
      end
      STEP_SPEED:  cw.op = OP_SPEED;
      STEP_ERR:    cw.op = OP_ERR;
      STEP_MUL_P:  cw.op = OP_MUL_P;
      STEP_ACC_P:  cw.op = OP_ACC_P;
      STEP_LOAD_D: cw.op = OP_LOAD_D;
      STEP_MUL_IH: cw.op = OP_MUL_IH;
      STEP_ADD_IH: cw.op = OP_ADD_IH;
      STEP_D_DIV: begin
        cw.op     = OP_DIV;
        cw.cond   = JMP_CNT_NZ;
        cw.target = STEP_D_DIV;
      end
      STEP_ACC_D:  cw.op = OP_ACC_D;
      STEP_ACC_I:  cw.op = OP_ACC_I;
      STEP_DRIVE:  cw.op = OP_DRIVE;
      STEP_HOLD: begin
        cw.cond   = JMP_OUT_BUSY;
        cw.target = STEP_HOLD;
      end
      STEP_FINISH: begin
        cw.op     = OP_FINISH;
        cw.cond   = JMP_ALWAYS;
        cw.target = STEP_WAIT;
      end
      default: begin
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/epps_stream_if.sv
// Valid/ready stream channel with a typed payload.
// The payload types come from epps_pkg at the point of instantiation.
`default_nettype none

interface epps_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/epps_mul.sv
// Registered 32 by 32 unsigned multiplier that carries a sign flag along with the product.
// Depends on nothing outside this file.
`default_nettype none

module epps_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        neg_i,
  output logic [63:0] prod_o,
  output logic        neg_o
);

  logic [63:0] prod_d;
  logic [63:0] prod_q;
  logic        neg_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_i;
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

`default_nettype wire

FILE: rtl/epps_datapath.sv
// Datapath of the speed loop: loop state, a bit-serial divider, the shared multiplier
// and the drive accumulator. Driven one operation a cycle; depends on epps_pkg, epps_mul.
`default_nettype none

module epps_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  epps_pkg::op_e           op_i,
  input  logic                    start_i,
  input  logic [31:0]             tick_i,
  input  epps_pkg::cfg_t          cfg_i,
  output epps_pkg::dp_status_t    status_o,
  output epps_pkg::out_t          result_o
);

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [39:0] abs40(input logic [39:0] x);
    return x[39] ? (~x + 40'd1) : x;
  endfunction

  // Loop state.
  logic [31:0]        last_tick_q;
  logic [31:0]        tally_q;
  logic               upd_q;
  logic [23:0]        speed_q;
  logic signed [24:0] last_err_q;
  logic signed [39:0] sum_q;
  logic signed [31:0] drive_q;

  // Working registers.
  logic [31:0]        tick_q;
  logic [31:0]        dt_q;
  logic [63:0]        num_q;
  logic [31:0]        rem_q;
  logic [5:0]         cnt_q;
  logic signed [24:0] err_q;
  logic signed [25:0] diff_q;
  logic [63:0]        acc_q;
  logic [71:0]        ireg_q;
  logic               dneg_q;
  logic               ineg_q;

  logic               skip;
  logic [32:0]        div_trial;
  logic [32:0]        div_diff;
  logic               div_ge;
  logic signed [24:0] err_w;
  logic signed [25:0] diff_w;
  logic signed [40:0] sum_wide;
  logic [39:0]        sum_sat;
  logic               prev_neg;
  logic               prev_pos;
  logic               err_neg;
  logic               err_pos;
  logic [39:0]        sum_next;
  logic [39:0]        sum_mag;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;
  logic [63:0]        prod;
  logic               prod_neg;
  logic [63:0]        prod_s;
  logic [63:0]        dmag;
  logic [63:0]        d_s;
  logic [63:0]        i_s;
  logic [63:0]        drive_ext;
  logic               acc_fits;
  logic [31:0]        drive_next;
  logic [23:0]        speed_next;

  assign skip = (last_tick_q == 32'd0) || !cfg_i.run_enable;

  // One restoring division step per cycle; the quotient shifts into the numerator.
  assign div_trial = {rem_q, num_q[63]};
  assign div_diff  = div_trial - {1'b0, dt_q};
  assign div_ge    = div_trial >= {1'b0, dt_q};

  // A quotient above 24 bits, including the all-ones result of a zero divisor, saturates.
  assign speed_next = (num_q[31:24] != 8'd0) ? epps_pkg::SPEED_MAX : num_q[23:0];

  assign err_w    = $signed({1'b0, cfg_i.target_speed}) - $signed({1'b0, speed_q});
  assign diff_w   = last_err_q - err_w;
  assign sum_wide = sum_q + err_w;
  assign sum_sat  = (sum_wide[40] != sum_wide[39]) ?
                    (sum_wide[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF) : sum_wide[39:0];
  assign prev_neg = last_err_q[24];
  assign prev_pos = !last_err_q[24] && (last_err_q != 25'sd0);
  assign err_neg  = err_w[24];
  assign err_pos  = !err_w[24] && (err_w != 25'sd0);
  // The integral restarts when the error changes sign.
  assign sum_next = ((prev_neg && err_pos) || (prev_pos && err_neg)) ? 40'd0 : sum_sat;

  assign sum_mag = abs40(sum_q);

  always_comb begin
    mul_a   = 32'd0;
    mul_b   = 32'd0;
    mul_neg = 1'b0;
    case (op_i)
      epps_pkg::OP_MUL_P: begin
        mul_a   = abs32(32'(err_q));
        mul_b   = abs32(cfg_i.prop_gain);
        mul_neg = err_q[24] ^ cfg_i.prop_gain[31];
      end
      epps_pkg::OP_ACC_P: begin
        mul_a   = abs32(32'(diff_q));
        mul_b   = abs32(cfg_i.deriv_gain);
        mul_neg = diff_q[25] ^ cfg_i.deriv_gain[31];
      end
      epps_pkg::OP_LOAD_D: begin
        mul_a = sum_mag[31:0];
        mul_b = abs32(cfg_i.int_gain);
      end
      epps_pkg::OP_MUL_IH: begin
        mul_a = {24'd0, sum_mag[39:32]};
        mul_b = abs32(cfg_i.int_gain);
      end
      default: begin
      end
    endcase
  end

  epps_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .neg_i  (mul_neg),
    .prod_o (prod),
    .neg_o  (prod_neg)
  );

  assign prod_s    = prod_neg ? (64'd0 - prod) : prod;
  // A zero tick difference gives no derivative term.
  assign dmag      = (dt_q == 32'd0) ? 64'd0 : {6'd0, num_q[57:0]};
  assign d_s       = dneg_q ? (64'd0 - dmag) : dmag;
  assign i_s       = ineg_q ? (64'd0 - ireg_q[63:0]) : ireg_q[63:0];
  assign drive_ext = {{32{drive_q[31]}}, drive_q};
  assign acc_fits  = (&acc_q[63:31]) || !(|acc_q[63:31]);
  assign drive_next = acc_fits ? acc_q[31:0] :
                      (acc_q[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q <= 32'd0;
      tally_q     <= 32'd0;
      upd_q       <= 1'b0;
      speed_q     <= 24'd0;
      last_err_q  <= 25'sd0;
      sum_q       <= 40'sd0;
      drive_q     <= 32'sd0;
    end else begin
      if (start_i) begin
        tally_q <= tally_q + 32'd1;
      end
      case (op_i)
        epps_pkg::OP_PREP:   upd_q <= !skip;
        epps_pkg::OP_SPEED:  speed_q <= speed_next;
        epps_pkg::OP_ERR: begin
          last_err_q <= err_w;
          sum_q      <= sum_next;
        end
        epps_pkg::OP_DRIVE:  drive_q <= drive_next;
        epps_pkg::OP_FINISH: last_tick_q <= tick_q;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tick_q <= tick_i;
    end
    case (op_i)
      epps_pkg::OP_PREP: begin
        dt_q  <= tick_q - last_tick_q;
        num_q <= {cfg_i.pulse_scale, 32'd0};
        rem_q <= 32'd0;
        cnt_q <= epps_pkg::SPEED_DIV_LAST;
      end
      epps_pkg::OP_DIV: begin
        rem_q <= div_ge ? div_diff[31:0] : div_trial[31:0];
        num_q <= {num_q[62:0], div_ge};
        cnt_q <= cnt_q - 6'd1;
      end
      epps_pkg::OP_ERR: begin
        err_q  <= err_w;
        diff_q <= diff_w;
      end
      epps_pkg::OP_ACC_P: acc_q <= drive_ext + prod_s;
      epps_pkg::OP_LOAD_D: begin
        num_q  <= {prod[57:0], 6'd0};
        rem_q  <= 32'd0;
        cnt_q  <= epps_pkg::D_DIV_LAST;
        dneg_q <= prod_neg;
      end
      epps_pkg::OP_MUL_IH: ireg_q <= {8'd0, prod};
      epps_pkg::OP_ADD_IH: begin
        ireg_q <= ireg_q + {prod[39:0], 32'd0};
        ineg_q <= sum_q[39] ^ cfg_i.int_gain[31];
      end
      epps_pkg::OP_ACC_D: begin
        acc_q  <= acc_q + d_s;
        ireg_q <= (ireg_q > epps_pkg::ITERM_LIM) ? epps_pkg::ITERM_LIM : ireg_q;
      end
      epps_pkg::OP_ACC_I: acc_q <= acc_q + i_s;
      default: begin
      end
    endcase
  end

  assign status_o.skip   = skip;
  assign status_o.cnt_nz = (cnt_q != 6'd0);

  assign result_o.pulse_total    = tally_q;
  assign result_o.updated        = upd_q;
  assign result_o.speed_measured = speed_q;
  assign result_o.drive_out      = drive_q;
  assign result_o.run_state      = cfg_i.run_enable;

endmodule

`default_nettype wire

FILE: rtl/epps_sequencer.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on epps_pkg for the program and the control word layout.
`default_nettype none

module epps_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  epps_pkg::seq_status_t  status_i,
  output epps_pkg::ctrl_t        ctrl_o,
  output logic                   idle_o
);

  epps_pkg::step_t step_q;
  epps_pkg::step_t step_d;
  epps_pkg::ctrl_t cw;
  logic            take;

  assign cw = epps_pkg::ucode(step_q);

  always_comb begin
    case (cw.cond)
      epps_pkg::JMP_NEVER:    take = 1'b0;
      epps_pkg::JMP_ALWAYS:   take = 1'b1;
      epps_pkg::JMP_NO_START: take = !status_i.start;
      epps_pkg::JMP_SKIP:     take = status_i.skip;
      epps_pkg::JMP_CNT_NZ:   take = status_i.cnt_nz;
      epps_pkg::JMP_OUT_BUSY: take = status_i.out_busy;
      default:                take = 1'b0;
    endcase
    step_d = take ? cw.target : step_q + epps_pkg::step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= epps_pkg::STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = cw;
  assign idle_o = (step_q == epps_pkg::STEP_WAIT);

endmodule

`default_nettype wire

FILE: rtl/encoder_period_pid_speed_loop.sv
// Encoder period speed loop with incremental PID drive: top level, config and result register.
// A new edge is taken only while the sequencer waits, so not before the last edge is finished.
// When the loop runs, the time per edge is set by the 32-step speed division
// and the 58-step derivative division on the shared bit-serial divider.
// Reset: loop state cleared, registers to their reset values, usable the cycle after reset.
`default_nettype none

module encoder_period_pid_speed_loop (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  epps_stream_if.sink                         in_if,
  epps_stream_if.source                       out_if,
  input  logic                                cfg_we_i,
  input  logic [epps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [epps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  epps_pkg::cfg_t        cfg_q;
  epps_pkg::ctrl_t       ctrl;
  epps_pkg::dp_status_t  dp_status;
  epps_pkg::seq_status_t seq_status;
  epps_pkg::out_t        result;
  epps_pkg::out_t        out_data_q;
  logic                  out_valid_q;
  logic                  idle;
  logic                  start;
  logic                  done;

  assign start = in_if.valid && idle;
  assign done  = (ctrl.op == epps_pkg::OP_FINISH);
  assign in_if.ready = idle;

  assign seq_status.start    = start;
  assign seq_status.skip     = dp_status.skip;
  assign seq_status.cnt_nz   = dp_status.cnt_nz;
  assign seq_status.out_busy = out_valid_q && !out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_scale  <= 32'd1000000;
      cfg_q.target_speed <= 24'd0;
      cfg_q.prop_gain    <= 32'sd983;
      cfg_q.int_gain     <= 32'sd0;
      cfg_q.deriv_gain   <= 32'sd0;
      cfg_q.run_enable   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        epps_pkg::CFG_PULSE_SCALE:  cfg_q.pulse_scale  <= cfg_data_i;
        epps_pkg::CFG_TARGET_SPEED: cfg_q.target_speed <= cfg_data_i[23:0];
        epps_pkg::CFG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data_i;
        epps_pkg::CFG_INT_GAIN:     cfg_q.int_gain     <= cfg_data_i;
        epps_pkg::CFG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data_i;
        epps_pkg::CFG_RUN_ENABLE:   cfg_q.run_enable   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  epps_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (seq_status),
    .ctrl_o   (ctrl),
    .idle_o   (idle)
  );

  epps_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (ctrl.op),
    .start_i  (start),
    .tick_i   (in_if.data.tick_time),
    .cfg_i    (cfg_q),
    .status_o (dp_status),
    .result_o (result)
  );

  // The result register lets the next edge be taken while a result still waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= result;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> !out_valid_q)
    else $error("result loaded while the previous one was not transferred");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> !in_if.ready)
    else $error("input ready right after a transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |=> (idle && out_valid_q))
    else $error("sequencer did not return to wait after finishing");
`endif

endmodule

`default_nettype wire

FILE: bench/encoder_period_pid_speed_loop_tb.sv
// Self-checking bench for the encoder period speed loop with incremental PID drive.
// Depends on epps_pkg, epps_stream_if and encoder_period_pid_speed_loop from the RTL.
// A bit-accurate predictor of the loop checks every edge report, field by field.
module encoder_period_pid_speed_loop_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_MAX       = 14;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 110;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 103;

  localparam logic [epps_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [epps_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam longint SPEED_TOP    = 64'sd16777215;
  localparam longint SUM_TOP      = 64'sd549755813887;
  localparam longint SUM_BOTTOM   = -64'sd549755813888;
  localparam longint DRIVE_TOP    = 64'sd2147483647;
  localparam longint DRIVE_BOTTOM = -64'sd2147483648;
  localparam logic [127:0] ITERM_CAP = 128'h4000_0000_0000_0000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [epps_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [epps_pkg::CFG_DATA_W-1:0] cfg_data;

  epps_stream_if #(.T(epps_pkg::in_t))  tick_if ();
  epps_stream_if #(.T(epps_pkg::out_t)) result_if ();

  encoder_period_pid_speed_loop DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (tick_if),
    .out_if     (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Register mirror and loop state of the predictor.
  logic [31:0] scale_q;
  logic [23:0] target_q;
  longint      p_gain_q, i_gain_q, d_gain_q;
  logic        run_q;
  logic [31:0] prev_tick_q, edge_tally_q;
  longint      prev_err_q, err_sum_q, drive_q, speed_q;

  logic [31:0]    tick_backlog[$];
  epps_pkg::out_t edge_reports[$];
  logic [31:0]    gen_tick;

  int unsigned pushed_count, report_count, update_count, setting_count, fault_count;
  int unsigned send_wait, recv_wait, recv_pause, stall_cycles;
  bit          quiet_in, quiet_out;

  function automatic int unsigned idle_draw(input bit quiet);
    return quiet ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  // Product of the error sum and the integral gain, magnitude clamped to 2^62.
  function automatic longint integral_term(input longint acc_sum, input longint gain);
    logic [63:0]  mag_s, mag_g;
    logic [127:0] prod;
    mag_s = (acc_sum < 0) ? -acc_sum : acc_sum;
    mag_g = (gain < 0) ? -gain : gain;
    prod  = {64'd0, mag_s} * {64'd0, mag_g};
    if (prod > ITERM_CAP) prod = ITERM_CAP;
    return ((acc_sum < 0) != (gain < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  task automatic speed_loop_step(input logic [31:0] tick);
    logic [31:0]    dt;
    longint         dt_l, err, prev, sum, dterm, acc;
    epps_pkg::out_t rep;
    edge_tally_q = edge_tally_q + 1;
    rep.updated  = 1'b0;
    if (prev_tick_q != 0 && run_q) begin
      dt   = tick - prev_tick_q;
      dt_l = longint'({32'd0, dt});
      if (dt == 0) begin
        speed_q = SPEED_TOP;
      end else begin
        speed_q = longint'({32'd0, scale_q / dt});
        if (speed_q > SPEED_TOP) speed_q = SPEED_TOP;
      end
      prev       = prev_err_q;
      err        = longint'({40'd0, target_q}) - speed_q;
      prev_err_q = err;
      sum        = err_sum_q + err;
      if (sum > SUM_TOP) sum = SUM_TOP;
      if (sum < SUM_BOTTOM) sum = SUM_BOTTOM;
      // The sum restarts whenever the error crosses zero.
      if ((prev < 0 && err > 0) || (prev > 0 && err < 0)) sum = 0;
      err_sum_q = sum;
      dterm     = (dt == 0) ? 0 : ((prev - err) * d_gain_q) / dt_l;
      acc       = drive_q + err * p_gain_q + dterm + integral_term(sum, i_gain_q);
      if (acc > DRIVE_TOP) acc = DRIVE_TOP;
      if (acc < DRIVE_BOTTOM) acc = DRIVE_BOTTOM;
      drive_q     = acc;
      rep.updated = 1'b1;
      update_count++;
    end
    prev_tick_q        = tick;
    rep.pulse_total    = edge_tally_q;
    rep.speed_measured = speed_q[23:0];
    rep.drive_out      = drive_q[31:0];
    rep.run_state      = run_q;
    edge_reports.push_back(rep);
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    fault_count++;
    $display("%0t result %0d: %s is %0h, expected %0h", $time, report_count, field, got,
             want);
  endtask

  task automatic check_report(input epps_pkg::out_t got);
    epps_pkg::out_t want;
    report_count++;
    if (edge_reports.size() == 0) begin
      flag_mismatch("result with nothing expected, pulse_total", got.pulse_total, 0);
    end else begin
      want = edge_reports.pop_front();
      if (got.pulse_total !== want.pulse_total)
        flag_mismatch("pulse_total", got.pulse_total, want.pulse_total);
      if (got.updated !== want.updated)
        flag_mismatch("updated", got.updated, want.updated);
      if (got.speed_measured !== want.speed_measured)
        flag_mismatch("speed_measured", got.speed_measured, want.speed_measured);
      if (got.drive_out !== want.drive_out)
        flag_mismatch("drive_out", got.drive_out, want.drive_out);
      if (got.run_state !== want.run_state)
        flag_mismatch("run_state", got.run_state, want.run_state);
    end
  endtask

  // Tick driver: a transfer feeds the predictor, then the next tick follows its gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      tick_if.data  <= '0;
      send_wait     <= 0;
    end else begin
      if (tick_if.valid && tick_if.ready) speed_loop_step(tick_if.data.tick_time);
      if (!tick_if.valid || tick_if.ready) begin
        if (send_wait != 0) begin
          tick_if.valid <= 1'b0;
          send_wait     <= send_wait - 1;
        end else if (tick_backlog.size() != 0) begin
          tick_if.valid <= 1'b1;
          tick_if.data  <= epps_pkg::in_t'(tick_backlog.pop_front());
          send_wait     <= idle_draw(quiet_in);
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer, then stalls for a drawn number of cycles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      recv_wait       <= 0;
    end else if (result_if.valid && result_if.ready) begin
      check_report(result_if.data);
      recv_pause = idle_draw(quiet_out);
      result_if.ready <= (recv_pause == 0);
      recv_wait       <= (recv_pause == 0) ? 0 : recv_pause - 1;
    end else if (!result_if.ready) begin
      if (recv_wait == 0) result_if.ready <= 1'b1;
      else recv_wait <= recv_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tick_if.valid && tick_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no transfer for %0d cycles, %0d of %0d results seen", $time, stall_cycles,
               report_count, pushed_count);
      $display("encoder_period_pid_speed_loop_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [epps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      epps_pkg::CFG_PULSE_SCALE:  scale_q  = value;
      epps_pkg::CFG_TARGET_SPEED: target_q = value[23:0];
      epps_pkg::CFG_PROP_GAIN:    p_gain_q = longint'(signed'(value));
      epps_pkg::CFG_INT_GAIN:     i_gain_q = longint'(signed'(value));
      epps_pkg::CFG_DERIV_GAIN:   d_gain_q = longint'(signed'(value));
      epps_pkg::CFG_RUN_ENABLE:   run_q    = value[0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(input logic [31:0] scale, input logic [31:0] target,
                               input logic [31:0] p, input logic [31:0] i,
                               input logic [31:0] d, input logic run);
    write_reg(epps_pkg::CFG_PULSE_SCALE, scale);
    write_reg(epps_pkg::CFG_TARGET_SPEED, target);
    write_reg(epps_pkg::CFG_PROP_GAIN, p);
    write_reg(epps_pkg::CFG_INT_GAIN, i);
    write_reg(epps_pkg::CFG_DERIV_GAIN, d);
    write_reg(epps_pkg::CFG_RUN_ENABLE, {31'd0, run});
    // Writes past the last register must leave everything unchanged.
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, $urandom);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic queue_tick(input logic [31:0] t);
    tick_backlog.push_back(t);
    pushed_count++;
    gen_tick = t;
  endtask

  task automatic wait_results();
    while (report_count != pushed_count) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase();
    int unsigned flavor, nom_dt, nom_speed, g, dt, pick;
    logic [31:0] scale, target, p, i, d;
    logic        run;
    flavor    = $urandom_range(0, 7);
    nom_dt    = $urandom_range(20, 20000);
    nom_speed = $urandom_range(0, 40000);
    // Scale and target put the measured speed close to the target, so the error swings.
    scale     = nom_dt * nom_speed;
    target    = nom_speed + $urandom_range(0, nom_speed / 4) - nom_speed / 8;
    g         = 1 << $urandom_range(8, 20);
    p         = int'($urandom_range(0, 2 * g)) - int'(g);
    g         = g >> 4;
    i         = int'($urandom_range(0, 2 * g)) - int'(g);
    d         = int'($urandom_range(0, 2 * g)) - int'(g);
    run       = (flavor != 7);
    if (flavor == 6) begin
      scale  = $urandom;
      target = $urandom;
      p      = $urandom;
      i      = $urandom;
      d      = $urandom;
    end
    if (scale == 0) scale = 1;
    quiet_in  = ($urandom_range(0, 3) == 0);
    quiet_out = ($urandom_range(0, 3) == 0);
    apply_setting(scale, target, p, i, d, run);
    if ($urandom_range(0, 2) == 0) queue_tick(32'hFFFF_FFFF - $urandom_range(0, 4 * nom_dt));
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      dt   = nom_dt + $urandom_range(0, nom_dt / 4) - nom_dt / 8;
      if (pick < 80)      queue_tick(gen_tick + dt);
      else if (pick < 88) queue_tick(gen_tick + $urandom_range(0, 3));
      else if (pick < 95) queue_tick($urandom);
      else if (pick < 98) queue_tick(32'd0);
      else                queue_tick(gen_tick + $urandom);
    end
    wait_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    scale_q         = 32'd1000000;
    target_q        = '0;
    p_gain_q        = 983;
    i_gain_q        = 0;
    d_gain_q        = 0;
    run_q           = 1'b0;
    prev_tick_q     = '0;
    edge_tally_q    = '0;
    prev_err_q      = 0;
    err_sum_q       = 0;
    drive_q         = 0;
    speed_q         = 0;
    gen_tick        = '0;
    quiet_in        = 1'b0;
    quiet_out       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: the loop is stopped, edges are only counted.
    queue_tick(32'd0);
    queue_tick(32'd100);
    queue_tick(32'd200);
    wait_results();

    // Nominal loop: zero error, sign change of the error, zero tick difference,
    // a zero timestamp and the edge after it, and wrapping timestamps.
    apply_setting(32'd1000000, 32'd1000, 32'd983, 32'h0000_0100, 32'h0001_0000, 1'b1);
    queue_tick(32'd1200);
    queue_tick(32'd2100);
    queue_tick(32'd3300);
    queue_tick(32'd3300);
    queue_tick(32'd0);
    queue_tick(32'd50);
    queue_tick(32'hFFFF_FFFF);
    queue_tick(32'h0000_0100);
    wait_results();

    // Largest scale, target and gains: speed and drive saturate high.
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  1'b1);
    queue_tick(32'h8000_0000);
    queue_tick(32'h8000_0001);
    queue_tick(32'h8000_1001);
    queue_tick(32'hFFFF_FFFF);
    queue_tick(32'h0000_0001);
    wait_results();

    // Smallest scale and most negative gains.
    apply_setting(32'd1, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_tick(32'h0000_0002);
    queue_tick(32'h0000_0003);
    queue_tick(32'h0000_0005);
    queue_tick(32'h5555_5555);
    queue_tick(32'hAAAA_AAAA);
    queue_tick(32'h0000_0003);
    wait_results();

    repeat (RANDOM_PHASES) random_phase();

    while (report_count != pushed_count) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (edge_reports.size() != 0)
      flag_mismatch("results never delivered, count", edge_reports.size(), 0);
    $display("%0d encoder edges checked, %0d of them ran the PID update, %0d register settings",
             report_count, update_count, setting_count);
    $display("%0d mismatches found", fault_count);
    if (fault_count == 0) begin
      $display("encoder_period_pid_speed_loop_tb: PASS");
    end else begin
      $display("encoder_period_pid_speed_loop_tb: FAIL");
    end
    $finish;
  end

endmodule
